FILE: rtl/rc3_pkg.sv
// shared types and constants for the rgb 3x3 convolution block
package rc3_pkg;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_COEF_BITS = 8;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int PIXEL_MAX     = 255;
	localparam int COL_W         = 12;
	localparam int DIM_W         = 13;
	localparam int IDX_W         = 3;

	localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [47:0]      RST_KROW0  = 48'd66561;
	localparam logic [47:0]      RST_KROW1  = 48'd265220;
	localparam logic [47:0]      RST_KROW2  = 48'd66561;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KROW0  = 3'd2,
		REG_KROW1  = 3'd3,
		REG_KROW2  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       frame_end;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic mac;
		logic div_init;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic mac_last;
		logic div_last;
	} sts_t;

endpackage

FILE: rtl/rc3_ram.sv
// generic simple dual-port ram with registered read
module rc3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rc3_cfg.sv
// configuration register file
module rc3_cfg #(
	parameter int COEF_BITS = rc3_pkg::DEF_COEF_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rc3_pkg::IDX_W-1:0]               cfg_index,
	input  logic [((3*COEF_BITS > 13) ? 3*COEF_BITS : 13)-1:0] cfg_data,
	output logic [rc3_pkg::DIM_W-1:0]               image_width,
	output logic [rc3_pkg::DIM_W-1:0]               image_height,
	output logic [2:0][3*COEF_BITS-1:0]             kernel
);

	localparam int KW = 3 * COEF_BITS;

	logic [rc3_pkg::DIM_W-1:0] width_q;
	logic [rc3_pkg::DIM_W-1:0] height_q;
	logic [2:0][KW-1:0]        krow_q;

	assign cfg_ready    = 1'b1;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign kernel       = krow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= rc3_pkg::RST_WIDTH;
			height_q  <= rc3_pkg::RST_HEIGHT;
			krow_q[0] <= rc3_pkg::RST_KROW0[KW-1:0];
			krow_q[1] <= rc3_pkg::RST_KROW1[KW-1:0];
			krow_q[2] <= rc3_pkg::RST_KROW2[KW-1:0];
		end else if (cfg_valid) begin
			case (rc3_pkg::cfg_reg_t'(cfg_index))
				rc3_pkg::REG_WIDTH: begin
					width_q <= cfg_data[rc3_pkg::DIM_W-1:0];
				end
				rc3_pkg::REG_HEIGHT: begin
					height_q <= cfg_data[rc3_pkg::DIM_W-1:0];
				end
				rc3_pkg::REG_KROW0: begin
					krow_q[0] <= cfg_data[KW-1:0];
				end
				rc3_pkg::REG_KROW1: begin
					krow_q[1] <= cfg_data[KW-1:0];
				end
				rc3_pkg::REG_KROW2: begin
					krow_q[2] <= cfg_data[KW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/rc3_ctrl.sv
// controller state machine: intake, window load, mac, divide, result
module rc3_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  rc3_pkg::sts_t sts,
	output rc3_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_MAC  = 6'b000100,
		S_DIVI = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_n  = sts.interior ? S_MAC : S_IDLE;
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				if (sts.mac_last) begin
					state_n = S_DIVI;
				end
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_n      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: rtl/rc3_dp.sv
// datapath: counters, line store, window, mac lanes, serial dividers
module rc3_dp #(
	parameter int MAX_WIDTH = rc3_pkg::DEF_MAX_WIDTH,
	parameter int COEF_BITS = rc3_pkg::DEF_COEF_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rc3_pkg::cmd_t                 cmd,
	output rc3_pkg::sts_t                 sts,
	input  rc3_pkg::in_word_t             in_word,
	input  logic [rc3_pkg::DIM_W-1:0]     image_width,
	input  logic [rc3_pkg::DIM_W-1:0]     image_height,
	input  logic [2:0][3*COEF_BITS-1:0]   kernel,
	output rc3_pkg::out_word_t            out_word
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int ACC_W  = COEF_BITS + 12;
	localparam int WS_W   = COEF_BITS + 4;
	localparam int CNT_W  = $clog2(ACC_W);
	localparam int COL_W  = rc3_pkg::COL_W;

	// frame position
	logic [COL_W-1:0] col_q, row_q;
	logic [31:0]      w_eff, h_eff, col32, row32, idx32;
	logic             row_last, frame_last;

	// item being worked
	logic [23:0]    pix_q;
	logic [AW-1:0]  idx_q;
	logic           interior_q, fend_q;
	logic [47:0]    rd_data;

	logic [2:0][2:0][23:0] win_q;

	logic [1:0]                   tap_r_q, tap_c_q;
	logic [23:0]                  tap_px;
	logic signed [COEF_BITS-1:0]  tap_cf;
	logic signed [ACC_W-1:0]      acc_q [3];
	logic signed [COEF_BITS+8:0]  prod [3];

	logic signed [WS_W-1:0] wsum;
	logic [WS_W-1:0]        dvs;
	logic [WS_W-1:0]        d_q;
	logic [ACC_W-1:0]       q_q [3];
	logic [WS_W:0]          rem_q [3];
	logic [WS_W:0]          rem_n [3];
	logic                   neg_q [3];
	logic [CNT_W-1:0]       cnt_q;

	always_comb begin
		col32 = 32'(col_q);
		row32 = 32'(row_q);
		w_eff = 32'(image_width);
		if (w_eff < 32'd3) begin
			w_eff = 32'd3;
		end else if (w_eff > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end
		h_eff = 32'(image_height);
		if (h_eff < 32'd3) begin
			h_eff = 32'd3;
		end else if (h_eff > 32'(rc3_pkg::HEIGHT_LIMIT)) begin
			h_eff = 32'(rc3_pkg::HEIGHT_LIMIT);
		end
		row_last   = col32 >= w_eff - 32'd1;
		frame_last = row32 >= h_eff - 32'd1;
		idx32      = (col32 < 32'(MAX_WIDTH)) ? col32 : 32'(MAX_WIDTH - 1);
	end

	// each entry holds {row before previous, previous row}
	rc3_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (idx_q),
		.wdata ({rd_data[23:0], pix_q}),
		.re    (cmd.accept),
		.raddr (idx32[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (row_last) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q      <= {in_word.in_red, in_word.in_green, in_word.in_blue};
			idx_q      <= idx32[AW-1:0];
			interior_q <= (col_q >= COL_W'(2)) && (row_q >= COL_W'(2));
			fend_q     <= row_last && frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cmd.load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_data[47:24];
			win_q[1][2] <= rd_data[23:0];
			win_q[2][2] <= pix_q;
		end
	end

	// one tap per cycle, three channel lanes
	assign tap_px = win_q[tap_r_q][tap_c_q];
	assign tap_cf = kernel[tap_c_q][tap_r_q*COEF_BITS +: COEF_BITS];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = $signed({1'b0, tap_px[8*ch +: 8]}) * tap_cf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_r_q <= '0;
			tap_c_q <= '0;
		end else if (cmd.load) begin
			tap_r_q <= '0;
			tap_c_q <= '0;
		end else if (cmd.mac) begin
			if (tap_c_q == 2'd2) begin
				tap_c_q <= '0;
				tap_r_q <= tap_r_q + 1'b1;
			end else begin
				tap_c_q <= tap_c_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.load) begin
				acc_q[ch] <= '0;
			end else if (cmd.mac) begin
				acc_q[ch] <= acc_q[ch] + ACC_W'(prod[ch]);
			end
		end
	end

	always_comb begin
		wsum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				wsum = wsum + WS_W'($signed(kernel[c][r*COEF_BITS +: COEF_BITS]));
			end
		end
		if (wsum == '0) begin
			dvs = WS_W'(1);
		end else if (wsum[WS_W-1]) begin
			dvs = -wsum;
		end else begin
			dvs = wsum;
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rem_n[ch] = {rem_q[ch][WS_W-1:0], q_q[ch][ACC_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			d_q <= dvs;
			for (int ch = 0; ch < 3; ch++) begin
				q_q[ch]   <= acc_q[ch][ACC_W-1] ? ACC_W'(-acc_q[ch]) : ACC_W'(acc_q[ch]);
				rem_q[ch] <= '0;
				neg_q[ch] <= acc_q[ch][ACC_W-1] ^ wsum[WS_W-1];
			end
		end else if (cmd.div_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_n[ch] >= {1'b0, d_q}) begin
					rem_q[ch] <= rem_n[ch] - {1'b0, d_q};
					q_q[ch]   <= {q_q[ch][ACC_W-2:0], 1'b1};
				end else begin
					rem_q[ch] <= rem_n[ch];
					q_q[ch]   <= {q_q[ch][ACC_W-2:0], 1'b0};
				end
			end
		end
	end

	function automatic logic [7:0] sat8(input logic [ACC_W-1:0] q, input logic neg);
		logic [7:0] v;
		if (neg) begin
			v = '0;
		end else if (q > ACC_W'(rc3_pkg::PIXEL_MAX)) begin
			v = 8'(rc3_pkg::PIXEL_MAX);
		end else begin
			v = q[7:0];
		end
		return v;
	endfunction

	assign out_word.out_blue  = sat8(q_q[0], neg_q[0]);
	assign out_word.out_green = sat8(q_q[1], neg_q[1]);
	assign out_word.out_red   = sat8(q_q[2], neg_q[2]);
	assign out_word.frame_end = fend_q;

	assign sts.interior = interior_q;
	assign sts.mac_last = (tap_r_q == 2'd2) && (tap_c_q == 2'd2);
	assign sts.div_last = (cnt_q == CNT_W'(ACC_W - 1));

endmodule

FILE: rtl/rgb_convolution_3x3_top.sv
// top level of the rgb 3x3 convolution filter
//  channel | signals                               | dir
//  input   | in_valid, in_stall, in_word           | pixel words in raster order
//  output  | out_valid, out_stall, out_word        | filtered interior pixel words
//  config  | cfg_valid, cfg_ready, cfg_index, data | register writes
// one word at a time: border pixels only pass intake and window load; interior
// pixels also pass the one-tap-per-cycle mac, the bit-serial divider and the
// result state, which waits for out_stall to drop
// no clearing pass after reset, line store contents are don't-care until written
// a stalled result holds, and no new word is taken until it leaves
module rgb_convolution_3x3_top #(
	parameter int MAX_WIDTH = rc3_pkg::DEF_MAX_WIDTH,
	parameter int COEF_BITS = rc3_pkg::DEF_COEF_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  rc3_pkg::in_word_t                       in_word,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output rc3_pkg::out_word_t                      out_word,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rc3_pkg::IDX_W-1:0]               cfg_index,
	input  logic [((3*COEF_BITS > 13) ? 3*COEF_BITS : 13)-1:0] cfg_data
);

	logic [rc3_pkg::DIM_W-1:0]  image_width, image_height;
	logic [2:0][3*COEF_BITS-1:0] kernel;
	rc3_pkg::cmd_t              cmd;
	rc3_pkg::sts_t              sts;

	rc3_cfg #(.COEF_BITS(COEF_BITS)) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.image_width  (image_width),
		.image_height (image_height),
		.kernel       (kernel)
	);

	rc3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rc3_dp #(.MAX_WIDTH(MAX_WIDTH), .COEF_BITS(COEF_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_word      (in_word),
		.image_width  (image_width),
		.image_height (image_height),
		.kernel       (kernel),
		.out_word     (out_word)
	);

endmodule

FILE: rtl/rc3_checker.sv
// port-level checks for the convolution top, bound to it
module rc3_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input rc3_pkg::out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("result word changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while one is in work");

	a_no_intake_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

endmodule

bind rgb_convolution_3x3_top rc3_checker u_rc3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

FILE: bench/rgb_convolution_3x3_top_tb.sv
// testbench for the rgb 3x3 convolution filter: directed and random frames against a predictor
`timescale 1ns / 1ps

module rgb_convolution_3x3_top_tb;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	rc3_pkg::in_word_t  in_word;
	logic               out_valid;
	logic               out_stall;
	rc3_pkg::out_word_t out_word;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [rc3_pkg::IDX_W-1:0] cfg_index;
	logic [23:0] cfg_data;

	rgb_convolution_3x3_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [23:0] prev_row [rc3_pkg::DEF_MAX_WIDTH];
	logic [23:0] older_row [rc3_pkg::DEF_MAX_WIDTH];
	logic [23:0] win [3][3];
	int unsigned col_n, row_n;
	logic [12:0] geo_w, geo_h;
	logic [23:0] krow [3];

	rc3_pkg::out_word_t filtered_q[$];
	int errors, pixels_sent, words_checked, frames_sent;
	int gap_percent;
	int stall_phase;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// filter one pixel into the predictor, queue the word it produces for interior pixels
	task automatic filter_pixel(input rc3_pkg::in_word_t p);
		int unsigned w, h, idx;
		logic [23:0] pix;
		bit row_last, frame_last;
		int k [3][3];
		int ksum, acc;
		rc3_pkg::out_word_t o;
		w = (geo_w < 3) ? 3 : (geo_w > rc3_pkg::DEF_MAX_WIDTH) ? rc3_pkg::DEF_MAX_WIDTH : geo_w;
		h = (geo_h < 3) ? 3 : (geo_h > rc3_pkg::HEIGHT_LIMIT) ? rc3_pkg::HEIGHT_LIMIT : geo_h;
		pix = {p.in_red, p.in_green, p.in_blue};
		idx = (col_n < rc3_pkg::DEF_MAX_WIDTH) ? col_n : rc3_pkg::DEF_MAX_WIDTH - 1;
		row_last = col_n >= w - 1;
		frame_last = row_n >= h - 1;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = older_row[idx];
		win[1][2] = prev_row[idx];
		win[2][2] = pix;
		older_row[idx] = prev_row[idx];
		prev_row[idx] = pix;
		if (col_n >= 2 && row_n >= 2) begin
			ksum = 0;
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++) begin
					k[r][c] = $signed(krow[c][r*8 +: 8]);
					ksum += k[r][c];
				end
			if (ksum == 0) ksum = 1;
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						acc += int'(win[r][c][8*ch +: 8]) * k[r][c];
				acc = acc / ksum;
				if (acc < 0) acc = 0;
				if (acc > rc3_pkg::PIXEL_MAX) acc = rc3_pkg::PIXEL_MAX;
				case (ch)
					0: o.out_blue = acc[7:0];
					1: o.out_green = acc[7:0];
					default: o.out_red = acc[7:0];
				endcase
			end
			o.frame_end = row_last && frame_last;
			filtered_q.push_back(o);
		end
		if (row_last) begin
			col_n = 0;
			row_n = frame_last ? 0 : ((row_n + 1) & 12'hFFF);
			if (frame_last) frames_sent++;
		end else begin
			col_n = (col_n + 1) & 12'hFFF;
		end
	endtask

	task automatic send_pixel(input rc3_pkg::in_word_t p);
		in_valid <= 1'b1;
		in_word <= p;
		do @(posedge clk); while (in_stall);
		filter_pixel(p);
		pixels_sent++;
		if ($urandom_range(99) < gap_percent) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		// border pixels may still be in flight
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input rc3_pkg::cfg_reg_t idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			rc3_pkg::REG_WIDTH:  geo_w = val[12:0];
			rc3_pkg::REG_HEIGHT: geo_h = val[12:0];
			rc3_pkg::REG_KROW0:  krow[0] = val;
			rc3_pkg::REG_KROW1:  krow[1] = val;
			rc3_pkg::REG_KROW2:  krow[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
		wait_idle();
		write_reg(rc3_pkg::REG_WIDTH, {11'd0, w});
		write_reg(rc3_pkg::REG_HEIGHT, {11'd0, h});
	endtask

	task automatic set_kernel(input logic [23:0] k0, input logic [23:0] k1,
			input logic [23:0] k2);
		wait_idle();
		write_reg(rc3_pkg::REG_KROW0, k0);
		write_reg(rc3_pkg::REG_KROW1, k1);
		write_reg(rc3_pkg::REG_KROW2, k2);
	endtask

	function automatic rc3_pkg::in_word_t rand_pixel();
		rc3_pkg::in_word_t p;
		p = 24'($urandom);
		if ($urandom_range(9) == 0) p.in_red = $urandom_range(1) ? 8'hFF : 8'h00;
		if ($urandom_range(9) == 0) p.in_green = $urandom_range(1) ? 8'hFF : 8'h00;
		if ($urandom_range(9) == 0) p.in_blue = $urandom_range(1) ? 8'hFF : 8'h00;
		return p;
	endfunction

	// one full frame at the current geometry
	task automatic send_frame(input int n, input int mode);
		for (int i = 0; i < n; i++)
			case (mode)
				0: send_pixel(rand_pixel());
				1: send_pixel(24'hFFFFFF);
				2: send_pixel(24'h000000);
				default: send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
			endcase
	endtask

	// default kernel on a 3x3 then 4x3 frame
	task automatic test_reset_kernel();
		set_geometry(13'd3, 13'd3);
		send_frame(9, 0);
		set_geometry(13'd4, 13'd3);
		send_frame(12, 3);
	endtask

	// all-ones, alternating, random and all-zero pixels against extreme kernels: max, negative sum, zero sum, mixed signs
	task automatic test_kernel_signs();
		set_geometry(13'd3, 13'd3);
		set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
		send_frame(9, 1);
		set_kernel(24'h808080, 24'h808080, 24'h808080);
		send_frame(9, 3);
		set_kernel(24'h01FF00, 24'h000000, 24'h00FF01);
		send_frame(9, 0);
		set_kernel(24'hFF08FF, 24'hFF00FF, 24'hFF00FF);
		send_frame(9, 2);
	endtask

	// undersized geometry saturates to a 3x3 frame
	task automatic test_geometry_limits();
		set_kernel(24'h010401, 24'h040C04, 24'h010401);
		set_geometry(13'd0, 13'd2);
		send_frame(9, 0);
		set_geometry(13'd1, 13'd1);
		send_frame(9, 0);
	endtask

	task automatic test_random_frames();
		int w, h;
		while (pixels_sent < 750) begin
			if ($urandom_range(3) == 0)
				set_kernel(24'($urandom), 24'($urandom), 24'($urandom));
			else if ($urandom_range(5) == 0)
				set_kernel(24'h010401, 24'h040C04, 24'h010401);
			w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
			h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
			set_geometry(13'(w), 13'(h));
			gap_percent = $urandom_range(2) * 20;
			send_frame(((w < 3) ? 3 : w) * ((h < 3) ? 3 : h), 0);
		end
	endtask

	// receiver stalls on its own pattern, sometimes not at all
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_phase <= 0;
			out_stall <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1;
			case ((stall_phase / 500) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(99) < 30);
				default: out_stall <= ((stall_phase % 37) < 12);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected word %h", out_word);
				errors++;
			end else begin
				rc3_pkg::out_word_t e;
				e = filtered_q.pop_front();
				if (out_word.out_blue !== e.out_blue) begin
					$error("out_blue exp %0d got %0d", e.out_blue, out_word.out_blue);
					errors++;
				end
				if (out_word.out_green !== e.out_green) begin
					$error("out_green exp %0d got %0d", e.out_green, out_word.out_green);
					errors++;
				end
				if (out_word.out_red !== e.out_red) begin
					$error("out_red exp %0d got %0d", e.out_red, out_word.out_red);
					errors++;
				end
				if (out_word.frame_end !== e.frame_end) begin
					$error("frame_end exp %0d got %0d", e.frame_end, out_word.frame_end);
					errors++;
				end
				words_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = rc3_pkg::REG_WIDTH;
		cfg_data = '0;
		errors = 0;
		pixels_sent = 0;
		words_checked = 0;
		frames_sent = 0;
		gap_percent = 20;
		for (int i = 0; i < rc3_pkg::DEF_MAX_WIDTH; i++) begin
			prev_row[i] = '0;
			older_row[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
		col_n = 0;
		row_n = 0;
		geo_w = rc3_pkg::RST_WIDTH;
		geo_h = rc3_pkg::RST_HEIGHT;
		krow[0] = rc3_pkg::RST_KROW0[23:0];
		krow[1] = rc3_pkg::RST_KROW1[23:0];
		krow[2] = rc3_pkg::RST_KROW2[23:0];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_kernel();
		test_kernel_signs();
		test_geometry_limits();
		test_random_frames();

		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d pixels in %0d frames, %0d filtered words checked",
			pixels_sent, frames_sent, words_checked);
		$display("kernels: default, extreme, zero and negative sums; small and undersized frames");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rc3_pkg.sv
rtl/rc3_ram.sv
rtl/rc3_cfg.sv
rtl/rc3_ctrl.sv
rtl/rc3_dp.sv
rtl/rgb_convolution_3x3_top.sv
rtl/rc3_checker.sv
bench/rgb_convolution_3x3_top_tb.sv
